// File: hw/rtl/tbg_pkg.sv
// Shared types, widths and saturation helpers for the tetrahedron basis gradient core.
// No dependencies; every other RTL file imports this package.
package tbg_pkg;

    localparam int CW     = 24;          // coordinate width, Q8.16
    localparam int CFRAC  = 16;
    localparam int EW     = CW + 1;      // edge vector component
    localparam int PW     = 2 * EW;      // cross product term
    localparam int XW     = PW + 1;      // cofactor of corners 1..3
    localparam int GW     = XW + 2;      // cofactor incl. corner 0
    localparam int DETW   = 78;          // determinant
    localparam int LOW    = 26;          // low split of the cofactor in the det multiply
    localparam int GRAD_W = 32;
    localparam int GFRAC  = 16;
    localparam int VOL_W  = 48;
    localparam int VFRAC  = 24;
    localparam int NW     = 86;          // divider numerator
    localparam int DW     = DETW + 1;    // divider denominator
    localparam int QW     = VOL_W;       // divider quotient register
    localparam int GQ     = GRAD_W;      // quotient bits for a gradient
    localparam int GSH    = CFRAC + GFRAC + 1;
    localparam int VSH    = 3 * CFRAC + 2 - VFRAC;
    localparam int IN_W   = 12 * CW;
    localparam int OUT_W  = 3 * GRAD_W + VOL_W;
    localparam int USER_W = 3;
    localparam logic [1:0] LAST_CORNER = 2'd3;
    localparam logic [1:0] LAST_AXIS   = 2'd2;

    typedef struct packed {
        logic [3:0][2:0][GW-1:0] g;
        logic [DETW-1:0]         det;
    } t_job;

    typedef struct packed {
        logic [NW-1:0] n;
        logic [DW-1:0] d;
        logic          wide;   // 48 quotient bits (volume), else 32
    } t_div_req;

    typedef struct packed {
        logic          done;
        logic          ovf;
        logic [QW-1:0] q;
    } t_div_res;

    function automatic int nxt3(input int i);
        return (i == 2) ? 0 : i + 1;
    endfunction

    function automatic logic [GRAD_W-1:0] sat_grad(input logic neg, input logic ovf,
                                                   input logic [QW-1:0] q);
        logic [GRAD_W-1:0] m;
        logic [GRAD_W-1:0] lim;
        m   = q[GRAD_W-1:0];
        lim = {1'b1, {(GRAD_W-1){1'b0}}};
        if (neg) begin
            return (ovf || m > lim) ? lim : GRAD_W'(-m);
        end
        return (ovf || m[GRAD_W-1]) ? ~lim : m;
    endfunction

    function automatic logic [VOL_W-1:0] sat_vol(input logic neg, input logic ovf,
                                                 input logic [QW-1:0] q);
        logic [VOL_W-1:0] m;
        logic [VOL_W-1:0] lim;
        m   = q[VOL_W-1:0];
        lim = {1'b1, {(VOL_W-1){1'b0}}};
        if (neg) begin
            return (ovf || m > lim) ? lim : VOL_W'(-m);
        end
        return (ovf || m[VOL_W-1]) ? ~lim : m;
    endfunction

endpackage

// File: hw/rtl/tbg_front.sv
// Front pipeline: accepts corner beats, forms edges, cofactors and the determinant.
// Depends on tbg_pkg. Seven stages with bubble collapse, stalls from the job queue.
module tbg_front
    import tbg_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tvalid,
    output logic            o_tready,
    input  logic [IN_W-1:0] i_tdata,
    output logic            o_job_valid,
    input  logic            i_job_ready,
    output t_job            o_job
);

    logic [6:0] r_v;
    logic [6:0] en;

    logic [3:0][2:0][CW-1:0]  r_c;
    logic signed [EW-1:0]     r_e   [3][3];
    logic signed [PW-1:0]     r_p   [3][3][2];
    logic signed [EW-1:0]     r_e02 [3];
    logic signed [XW-1:0]     r_g3  [3][3];
    logic signed [EW-1:0]     r_e03 [3];
    logic signed [GW-1:0]     r_g4  [4][3];
    logic signed [PW+1:0]     r_plo [3];
    logic signed [PW-1:0]     r_phi [3];
    logic signed [GW-1:0]     r_g5  [4][3];
    logic signed [PW+3:0]     r_slo;
    logic signed [PW+1:0]     r_shi;
    logic signed [GW-1:0]     r_g6  [4][3];
    logic signed [DETW-1:0]   r_det;

    always_comb begin
        en[6] = !r_v[6] || i_job_ready;
        for (int k = 5; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_tready    = en[0];
    assign o_job_valid = r_v[6];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            for (int a = 0; a < 3; a++) begin
                o_job.g[k][a] = r_g6[k][a];
            end
        end
        o_job.det = r_det;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_tvalid;
            end
            for (int k = 1; k < 7; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int k = 0; k < 4; k++) begin
                for (int a = 0; a < 3; a++) begin
                    r_c[k][a] <= i_tdata[(k*3+a)*CW +: CW];
                end
            end
        end
        if (en[1]) begin
            for (int k = 0; k < 3; k++) begin
                for (int a = 0; a < 3; a++) begin
                    r_e[k][a] <= EW'($signed(r_c[k+1][a])) - EW'($signed(r_c[0][a]));
                end
            end
        end
        // cofactor j belongs to corner j+1: e(j+1) x e(j+2)
        if (en[2]) begin
            for (int j = 0; j < 3; j++) begin
                for (int a = 0; a < 3; a++) begin
                    r_p[j][a][0] <= r_e[nxt3(j)][nxt3(a)] * r_e[nxt3(nxt3(j))][nxt3(nxt3(a))];
                    r_p[j][a][1] <= r_e[nxt3(j)][nxt3(nxt3(a))] * r_e[nxt3(nxt3(j))][nxt3(a)];
                end
            end
            for (int a = 0; a < 3; a++) begin
                r_e02[a] <= r_e[0][a];
            end
        end
        if (en[3]) begin
            for (int j = 0; j < 3; j++) begin
                for (int a = 0; a < 3; a++) begin
                    r_g3[j][a] <= XW'(r_p[j][a][0]) - XW'(r_p[j][a][1]);
                end
            end
            for (int a = 0; a < 3; a++) begin
                r_e03[a] <= r_e02[a];
            end
        end
        // det = e0 . g1, cofactor split in two to keep the multipliers narrow
        if (en[4]) begin
            for (int a = 0; a < 3; a++) begin
                for (int j = 0; j < 3; j++) begin
                    r_g4[j+1][a] <= GW'(r_g3[j][a]);
                end
                r_g4[0][a] <= -(GW'(r_g3[0][a]) + GW'(r_g3[1][a]) + GW'(r_g3[2][a]));
                r_plo[a] <= r_e03[a] * $signed({1'b0, r_g3[0][a][LOW-1:0]});
                r_phi[a] <= r_e03[a] * $signed(r_g3[0][a][XW-1:LOW]);
            end
        end
        if (en[5]) begin
            r_g5  <= r_g4;
            r_slo <= (PW+4)'(r_plo[0]) + (PW+4)'(r_plo[1]) + (PW+4)'(r_plo[2]);
            r_shi <= (PW+2)'(r_phi[0]) + (PW+2)'(r_phi[1]) + (PW+2)'(r_phi[2]);
        end
        if (en[6]) begin
            r_g6  <= r_g5;
            r_det <= (DETW'(r_shi) <<< LOW) + DETW'(r_slo);
        end
    end

endmodule

// File: hw/rtl/tbg_queue.sv
// Two-entry job queue between the front pipeline and the divide sequencer.
// Depends on tbg_pkg for the job type.
module tbg_queue
    import tbg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// File: hw/rtl/tbg_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, with up-front overflow check.
// Depends on tbg_pkg. 32 or 48 steps per division.
module tbg_div
    import tbg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_div_req i_req,
    output t_div_res o_res
);

    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_d;
    logic [QW-1:0]    r_num;
    logic [QW-1:0]    r_q;
    logic             r_ovf;
    logic [5:0]       r_cnt;
    logic             r_done;
    logic [NW-GQ-1:0] hi;
    logic [DW:0]      t;
    logic             ge;

    always_comb begin
        hi = i_req.wide ? (NW-GQ)'(i_req.n[NW-1:QW]) : i_req.n[NW-1:GQ];
        t  = {r_rem, r_num[QW-1]};
        ge = (t >= {1'b0, r_d});
    end

    assign o_res.done = r_done;
    assign o_res.ovf  = r_ovf;
    assign o_res.q    = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= i_req.wide ? 6'(QW) : 6'(GQ);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DW'(hi);
            r_d   <= i_req.d;
            r_ovf <= (DW'(hi) >= i_req.d);
            r_num <= i_req.wide ? i_req.n[QW-1:0] : {i_req.n[GQ-1:0], {(QW-GQ){1'b0}}};
            r_q   <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? DW'(t - {1'b0, r_d}) : t[DW-1:0];
            r_num <= {r_num[QW-2:0], 1'b0};
            r_q   <= {r_q[QW-2:0], ge};
        end
    end

endmodule

// File: hw/rtl/tbg_back.sv
// Back end: takes one job, runs volume and twelve gradient divisions, emits four beats.
// Depends on tbg_pkg and tbg_div. Output register decouples the result channel.
module tbg_back
    import tbg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    output logic              o_job_ready,
    input  t_job              i_job,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [OUT_W-1:0]  o_tdata,
    output logic [USER_W-1:0] o_tuser,
    output logic              o_tlast
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_WAIT  = 4'b0100,
        S_PUT   = 4'b1000
    } t_bstate;

    t_bstate           r_state;
    t_bstate           n_state;
    t_job              r_job;
    logic [DETW-1:0]   r_absd;
    logic              r_dneg;
    logic              r_degen;
    logic              r_isvol;
    logic              r_neg;
    logic [1:0]        r_k;
    logic [1:0]        r_a;
    logic [VOL_W-1:0]  r_vol;
    logic [GRAD_W-1:0] r_grad [3];
    logic              r_ovalid;
    logic [OUT_W-1:0]  r_odata;
    logic [USER_W-1:0] r_ouser;
    logic              r_olast;
    logic [63:0]       r_vn;
    logic [63:0]       r_vq;
    logic [1:0]        r_vr;
    logic [2:0]        r_vcnt;
    logic              r_vdone;

    t_div_req          req;
    t_div_res          res;
    logic              start;
    logic              vstart;
    logic              fin;
    logic              cur_neg;
    logic              put;
    logic              take;
    logic signed [GW-1:0] g;
    logic [GW-1:0]     gmag;
    logic [DETW:0]     vsum;
    logic              det_neg;
    logic [17:0]       vpart;
    logic [35:0]       vprod;
    logic [15:0]       vdig;
    logic [17:0]       vrem;

    localparam logic [DETW:0] VOL_BIAS = (DETW+1)'(3) << (VSH - 1);
    // ceil(2^19 / 3): exact floor division by three for operands below 2^19
    localparam logic [17:0]   RECIP3   = 18'd174763;

    always_comb begin
        g       = $signed(r_job.g[r_k][r_a]);
        gmag    = g[GW-1] ? GW'(-g) : GW'(g);
        vsum    = {r_absd, 1'b0} + VOL_BIAS;
        det_neg = i_job.det[DETW-1];
        req.n    = {gmag, {GSH{1'b0}}} + NW'(r_absd);
        req.d    = {r_absd, 1'b0};
        req.wide = 1'b0;
        cur_neg  = r_isvol ? r_dneg : (g[GW-1] ^ r_dneg);
        // volume: divide by three, 16 quotient bits per cycle from the top
        vpart = {r_vr, r_vn[63:48]};
        vprod = vpart * RECIP3;
        vdig  = vprod[34:19];
        vrem  = vpart - (18'(vdig) * 18'd3);
        take   = (r_state == S_IDLE) && i_job_valid;
        start  = (r_state == S_ISSUE) && !r_degen && !r_isvol;
        vstart = (r_state == S_ISSUE) && !r_degen && r_isvol;
        fin    = ((r_state == S_ISSUE) && r_degen) ||
                 ((r_state == S_WAIT) && (r_isvol ? r_vdone : res.done));
        put    = (r_state == S_PUT) && (!r_ovalid || i_tready);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) n_state = S_ISSUE;
            end
            S_ISSUE, S_WAIT: begin
                if (start || vstart) begin
                    n_state = S_WAIT;
                end else if (fin) begin
                    n_state = (!r_isvol && r_a == LAST_AXIS) ? S_PUT : S_ISSUE;
                end
            end
            S_PUT: begin
                if (put) n_state = (r_k == LAST_CORNER) ? S_IDLE : S_ISSUE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    tbg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (req),
        .o_res   (res)
    );

    assign o_job_ready = (r_state == S_IDLE);
    assign o_tvalid    = r_ovalid;
    assign o_tdata     = r_odata;
    assign o_tuser     = r_ouser;
    assign o_tlast     = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_vcnt   <= '0;
            r_vdone  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (put) begin
                r_ovalid <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
            r_vdone <= 1'b0;
            if (vstart) begin
                r_vcnt <= 3'd4;
            end else if (r_vcnt != '0) begin
                r_vcnt <= r_vcnt - 3'd1;
                if (r_vcnt == 3'd1) begin
                    r_vdone <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job   <= i_job;
            r_dneg  <= det_neg;
            r_absd  <= det_neg ? DETW'(-i_job.det) : i_job.det;
            r_degen <= (i_job.det == '0);
            r_isvol <= 1'b1;
            r_k     <= '0;
            r_a     <= '0;
        end
        if (start || vstart) begin
            r_neg <= cur_neg;
        end
        if (vstart) begin
            r_vn <= 64'(vsum[DETW:VSH]);
            r_vr <= '0;
            r_vq <= '0;
        end else if (r_vcnt != '0) begin
            r_vn <= {r_vn[47:0], 16'd0};
            r_vr <= vrem[1:0];
            r_vq <= {r_vq[47:0], vdig};
        end
        if (fin) begin
            if (r_isvol) begin
                r_vol   <= r_degen ? '0 : sat_vol(r_neg, r_vq[63:48] != '0, r_vq[47:0]);
                r_isvol <= 1'b0;
            end else begin
                r_grad[r_a] <= r_degen ? '0 : sat_grad(r_neg, res.ovf, res.q);
                if (r_a != LAST_AXIS) begin
                    r_a <= r_a + 2'd1;
                end
            end
        end
        if (put) begin
            r_odata <= {r_vol, r_grad[2], r_grad[1], r_grad[0]};
            r_ouser <= {r_degen, r_k};
            r_olast <= (r_k == LAST_CORNER);
            r_k     <= r_k + 2'd1;
            r_a     <= '0;
        end
    end

endmodule

// File: hw/rtl/tet_basis_gradient_core.sv
// Channel  | Dir | Beat contents
// s_axis   | in  | tdata: x0,y0,z0,x1,y1,z1,x2,y2,z2,x3,y3,z3 (24 bits each, Q8.16)
// m_axis   | out | tdata: grad_x,grad_y,grad_z (Q16.16), volume (Q24.24); tuser; tlast
//
// The front pipeline keeps taking beats while a two-job queue has room.
// The back end works on one job at a time with the single bit-serial divider (twelve
// 32-step gradient divisions; the volume's divide by three runs apart from it, 16 bits a
// step); degenerate jobs skip the divisions.
// Synchronous active-low reset clears all valids and the sequencer; data regs are not reset.
// A stalled output holds its beat; the back end waits in its emit state until it is taken.
module tet_basis_gradient_core
    import tbg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tvalid,
    output logic              o_tready,
    input  logic [IN_W-1:0]   i_tdata,   // x_node0,y_node0,z_node0 .. x_node3,y_node3,z_node3
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [OUT_W-1:0]  o_tdata,   // grad_x, grad_y, grad_z, volume
    output logic [USER_W-1:0] o_tuser,   // corner[1:0], degenerate
    output logic              o_tlast
);

    logic f_valid;
    logic f_ready;
    t_job f_job;
    logic q_valid;
    logic q_ready;
    t_job q_job;

    tbg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tvalid    (i_tvalid),
        .o_tready    (o_tready),
        .i_tdata     (i_tdata),
        .o_job_valid (f_valid),
        .i_job_ready (f_ready),
        .o_job       (f_job)
    );

    tbg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_job   (f_job),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_job   (q_job)
    );

    tbg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .o_job_ready (q_ready),
        .i_job       (q_job),
        .o_tvalid    (o_tvalid),
        .i_tready    (i_tready),
        .o_tdata     (o_tdata),
        .o_tuser     (o_tuser),
        .o_tlast     (o_tlast)
    );

endmodule

// File: hw/rtl/tbg_checker.sv
// Port-level checks for the tetrahedron basis gradient core, bound to the top level.
// Depends on tbg_pkg for widths.
module tbg_checker
    import tbg_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_tvalid,
    input logic              o_tready,
    input logic [IN_W-1:0]   i_tdata,
    input logic              o_tvalid,
    input logic              i_tready,
    input logic [OUT_W-1:0]  o_tdata,
    input logic [USER_W-1:0] o_tuser,
    input logic              o_tlast
);

    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_tvalid)
        else $error("output valid after reset");

    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tvalid |-> (o_tlast == (o_tuser[1:0] == LAST_CORNER)))
        else $error("tlast does not match the last corner");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && o_tuser[2]) |-> (o_tdata == '0))
        else $error("degenerate beat carries nonzero data");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && !i_tready) |=> (o_tvalid && $stable(o_tdata) && $stable(o_tuser)))
        else $error("stalled beat changed");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tvalid && !o_tready) |=> (i_tvalid && $stable(i_tdata)))
        else $error("input beat withdrawn or changed while waiting");

endmodule

bind tet_basis_gradient_core tbg_checker u_tbg_checker (.*);

// File: tb/tet_basis_gradient_core_tb.sv
// Self-checking testbench for tet_basis_gradient_core: corner sets in, four gradient beats out.
// Depends on tbg_pkg and the core RTL; the expected beats come from a wide-integer predictor.
module tet_basis_gradient_core_tb;
    import tbg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 3000;
    localparam int TAIL_CYCLES    = 600;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [1:0]        corner;
        logic [GRAD_W-1:0] gx, gy, gz;
        logic [VOL_W-1:0]  vol;
        logic              degen;
        logic              last;
    } grad_beat_t;

    typedef logic signed [CW-1:0] coord_t;

    // round to nearest, ties away from zero
    function automatic wide_t div_round(input wide_t n, input wide_t d);
        wide_t un, ud, q;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q  = (2 * un + ud) / (2 * ud);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic logic [63:0] clamp(input wide_t a, input int bits);
        wide_t lim;
        lim = wide_t'(1) <<< (bits - 1);
        if (a > lim - 1) return 64'(lim - 1);
        if (a < -lim)    return 64'(-lim);
        return 64'(a);
    endfunction

    class grad_scoreboard;
        grad_beat_t pending[$];
        int         mismatches;

        task report(input string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        // predicts the four corner beats of one accepted tetrahedron
        function void note_tet(input logic [IN_W-1:0] data);
            wide_t p[4][3], e[3][3], g[4][3], det, v;
            logic [VOL_W-1:0] vol;
            grad_beat_t b;
            for (int k = 0; k < 4; k++)
                for (int a = 0; a < 3; a++)
                    p[k][a] = wide_t'($signed(data[(k*3+a)*CW +: CW]));
            for (int k = 0; k < 3; k++)
                for (int a = 0; a < 3; a++)
                    e[k][a] = p[k+1][a] - p[0][a];
            for (int k = 1; k < 4; k++) begin
                int i, j;
                i = (k == 1) ? 1 : (k == 2) ? 2 : 0;
                j = (k == 1) ? 2 : (k == 2) ? 0 : 1;
                g[k][0] = e[i][1] * e[j][2] - e[i][2] * e[j][1];
                g[k][1] = e[i][2] * e[j][0] - e[i][0] * e[j][2];
                g[k][2] = e[i][0] * e[j][1] - e[i][1] * e[j][0];
            end
            for (int a = 0; a < 3; a++) g[0][a] = -(g[1][a] + g[2][a] + g[3][a]);
            det = e[0][0] * g[1][0] + e[0][1] * g[1][1] + e[0][2] * g[1][2];
            vol = '0;
            if (det != 0) begin
                v   = div_round(det <<< VFRAC, wide_t'(6) <<< (3 * CFRAC));
                vol = VOL_W'(clamp(v, VOL_W));
            end
            for (int k = 0; k < 4; k++) begin
                b.corner = 2'(k);
                b.degen  = (det == 0);
                b.last   = (k == 3);
                b.vol    = vol;
                b.gx = '0; b.gy = '0; b.gz = '0;
                if (det != 0) begin
                    b.gx = GRAD_W'(clamp(div_round(g[k][0] <<< (CFRAC + GFRAC), det), GRAD_W));
                    b.gy = GRAD_W'(clamp(div_round(g[k][1] <<< (CFRAC + GFRAC), det), GRAD_W));
                    b.gz = GRAD_W'(clamp(div_round(g[k][2] <<< (CFRAC + GFRAC), det), GRAD_W));
                end
                pending = {pending, b};
            end
        endfunction

        task check_beat(input logic [OUT_W-1:0] data, input logic [USER_W-1:0] user,
                        input logic lst);
            grad_beat_t x;
            if (pending.size() == 0) begin
                report("output beat with nothing expected");
                return;
            end
            x = pending.pop_front();
            if (user[1:0] != x.corner)
                report($sformatf("corner %0d, expected %0d", user[1:0], x.corner));
            if (data[31:0] != x.gx)
                report($sformatf("corner %0d grad_x %h, expected %h", x.corner, data[31:0], x.gx));
            if (data[63:32] != x.gy)
                report($sformatf("corner %0d grad_y %h, expected %h", x.corner, data[63:32], x.gy));
            if (data[95:64] != x.gz)
                report($sformatf("corner %0d grad_z %h, expected %h", x.corner, data[95:64], x.gz));
            if (data[143:96] != x.vol)
                report($sformatf("volume %h, expected %h", data[143:96], x.vol));
            if (user[2] != x.degen)
                report($sformatf("degenerate %b, expected %b", user[2], x.degen));
            if (lst != x.last)
                report($sformatf("tlast %b, expected %b", lst, x.last));
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_tvalid = 1'b0;
    logic              o_tready;
    logic [IN_W-1:0]   i_tdata = '0;
    logic              o_tvalid;
    logic              i_tready = 1'b0;
    logic [OUT_W-1:0]  o_tdata;
    logic [USER_W-1:0] o_tuser;
    logic              o_tlast;

    tet_basis_gradient_core uut (.*);

    always #6 i_clk = ~i_clk;

    grad_scoreboard sb = new();
    int  src_gap_pct  = 27;
    int  sink_idle_pct = 88;
    bit  sink_hold    = 1'b0;
    int  quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_tvalid && o_tready) sb.note_tet(i_tdata);
            if (o_tvalid && i_tready) sb.check_beat(o_tdata, o_tuser, o_tlast);
            if ((i_tvalid && o_tready) || (o_tvalid && i_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        i_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
    end

    function automatic logic [IN_W-1:0] pack_tet(input coord_t c[12]);
        logic [IN_W-1:0] d;
        for (int i = 0; i < 12; i++) d[i*CW +: CW] = c[i];
        return d;
    endfunction

    // called at a falling edge; returns at a falling edge with valid still high
    task send_tet(input coord_t c[12]);
        while ($urandom_range(99) < src_gap_pct) begin
            i_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_tvalid <= 1'b1;
        i_tdata  <= pack_tet(c);
        @(posedge i_clk);
        while (!o_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic coord_t rnd_coord(input int span);
        if (span == 0) return coord_t'($urandom);
        return coord_t'($signed($urandom_range(2 * span)) - span);
    endfunction

    task send_random(input int n);
        coord_t c[12];
        int kind;
        for (int t = 0; t < n; t++) begin
            kind = $urandom_range(9);
            for (int i = 0; i < 12; i++)
                c[i] = rnd_coord(kind < 5 ? 0 : kind < 8 ? 65536 * 4 : 300);
            if (kind == 8) begin
                // fourth corner in the plane of the other three
                for (int a = 0; a < 3; a++) c[9+a] = c[3+a] + c[6+a] - c[a];
            end else if (kind == 9 && $urandom_range(1)) begin
                // thin sliver: tiny height over a wide base, gradients saturate
                c = '{default: 0};
                c[3] = rnd_coord(0); c[7] = rnd_coord(0); c[11] = rnd_coord(3);
            end
            send_tet(c);
        end
    endtask

    localparam coord_t CMAX = coord_t'(24'h7fffff);
    localparam coord_t CMIN = coord_t'(24'h800000);
    localparam coord_t ONE  = coord_t'(1 << CFRAC);

    initial begin
        coord_t c[12];
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // all corners coincident
        c = '{default: 0};
        send_tet(c);
        // unit right tetrahedron and its mirror image
        c = '{0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
        send_tet(c);
        c = '{0, 0, 0, 0, ONE, 0, ONE, 0, 0, 0, 0, ONE};
        send_tet(c);
        // largest spread across the whole coordinate range
        c = '{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX};
        send_tet(c);
        c = '{CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN};
        send_tet(c);
        // flat tetrahedra
        c = '{0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, ONE, 0};
        send_tet(c);
        c = '{CMAX, 0, 0, CMIN, 0, 0, 0, 0, 0, 5, 0, 0};
        send_tet(c);
        // minimal height under a huge base: gradients clamp both ways
        c = '{0, 0, 0, CMAX, 0, 0, 0, CMAX, 0, 0, 0, 1};
        send_tet(c);
        c = '{0, 0, 0, CMIN, 0, 0, 0, CMAX, 0, 0, 0, 1};
        send_tet(c);
        // smallest non-zero volume
        c = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_tet(c);
        c = '{-1, -1, -1, 0, -1, -1, -1, 0, -1, -1, -1, -2};
        send_tet(c);
        // every bit pattern alternated
        c = '{24'h555555, 24'haaaaaa, 0, 24'haaaaaa, 24'h555555, 0, 0, 0, 24'h555555,
              24'hffffff, 24'h000001, 24'h7fffff};
        send_tet(c);

        send_random(160);
        src_gap_pct = 88; sink_idle_pct = 27;
        send_random(160);
        src_gap_pct = 0; sink_idle_pct = 0;
        fork
            begin
                sink_hold = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                sink_hold = 1'b0;
            end
            send_random(160);
        join
        i_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
